[src/rps_pkg.sv]
// Package for the radix partition scatter block.
// Holds the field widths, partition constants, op codes, queue entry type and the packing function.
// No dependencies.
package rps_pkg;

    localparam int PARTITION_BITS = 10;
    localparam int ROW_ID_BITS    = 27;
    localparam int KEY_BITS       = 32;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int RID_W   = 27;
    localparam int SEL_W   = 10;
    localparam int ADDR_W  = 32;
    localparam int WORD_W  = 64;
    localparam int COUNT_W = 32;

    localparam int NUM_PARTS  = 1 << PARTITION_BITS;
    localparam int PACK_SHIFT = PARTITION_BITS + ROW_ID_BITS;

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCATTER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [PARTITION_BITS-1:0] part_idx_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SCATTER,
        OP_FLUSH,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                op;
        part_idx_t          idx;
        logic [ADDR_W-1:0]  base_value;
        logic [WORD_W-1:0]  packed_word;
    } queue_entry_t;

    // High key bits go above the payload field; with these widths they fit within the word.
    function automatic logic [WORD_W-1:0] pack_tuple(input logic [KEY_W-1:0] key,
                                                     input logic [RID_W-1:0] rid);
        logic [WORD_W-1:0] high;
        high = WORD_W'(key) >> PARTITION_BITS;
        return WORD_W'(rid) + (high << PACK_SHIFT);
    endfunction

endpackage

[src/rps_if.sv]
// Handshake channels of the radix partition scatter block: input items and result items.
// Depends on rps_pkg for the field widths.
interface rps_in_if;
    logic                        valid;
    logic                        ready;
    logic [rps_pkg::FUNC_W-1:0]  func;
    logic [rps_pkg::KEY_W-1:0]   tuple_key;
    logic [rps_pkg::RID_W-1:0]   row_id;
    logic [rps_pkg::SEL_W-1:0]   part_sel;
    logic [rps_pkg::ADDR_W-1:0]  base_value;

    modport source (output valid, func, tuple_key, row_id, part_sel, base_value,
                    input ready);
    modport sink   (input valid, func, tuple_key, row_id, part_sel, base_value,
                    output ready);
endinterface

interface rps_out_if;
    logic                         valid;
    logic                         ready;
    logic [rps_pkg::SEL_W-1:0]    part_id;
    logic [rps_pkg::ADDR_W-1:0]   write_addr;
    logic [rps_pkg::WORD_W-1:0]   packed_word;
    logic [rps_pkg::COUNT_W-1:0]  fill_count;

    modport source (output valid, part_id, write_addr, packed_word, fill_count,
                    input ready);
    modport sink   (input valid, part_id, write_addr, packed_word, fill_count,
                    output ready);
endinterface

[src/rps_front.sv]
// Front end: accepts input items, decodes the function and selects the partition.
// Depends on rps_pkg and rps_if; feeds rps_queue.
module rps_front
(
    rps_in_if.sink               tuples,
    input  logic                 clearing,
    output logic                 push_valid,
    input  logic                 push_ready,
    output rps_pkg::queue_entry_t push_data
);

    logic [rps_pkg::KEY_W-1:0] key_m;

    assign key_m = tuples.tuple_key & rps_pkg::KEY_MASK;

    // hold off the source until the count memory sweep is done
    assign tuples.ready = push_ready && !clearing;
    assign push_valid   = tuples.valid && !clearing;

    always_comb
    begin
        push_data.base_value  = tuples.base_value;
        push_data.packed_word = '0;
        case (tuples.func)
            rps_pkg::FUNC_LOAD:
            begin
                push_data.op  = rps_pkg::OP_LOAD;
                push_data.idx = rps_pkg::part_idx_t'(tuples.part_sel);
            end
            rps_pkg::FUNC_SCATTER:
            begin
                push_data.op          = rps_pkg::OP_SCATTER;
                push_data.idx         = rps_pkg::part_idx_t'(key_m);
                push_data.packed_word = rps_pkg::pack_tuple(key_m, tuples.row_id);
            end
            rps_pkg::FUNC_FLUSH:
            begin
                push_data.op  = rps_pkg::OP_FLUSH;
                push_data.idx = rps_pkg::part_idx_t'(tuples.part_sel);
            end
            default:
            begin
                push_data.op  = rps_pkg::OP_NONE;
                push_data.idx = '0;
            end
        endcase
    end

endmodule

[src/rps_queue.sv]
// Short queue between the front end and the back end of the scatter block.
// Depends on rps_pkg for the entry type and depth.
module rps_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rps_pkg::queue_entry_t push_data,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output rps_pkg::queue_entry_t pop_data
);

    rps_pkg::queue_entry_t entries_reg [rps_pkg::QUEUE_DEPTH];

    logic [rps_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rps_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rps_pkg::QPTR_W:0]   used_reg, used_next;
    logic                       push_fire, pop_fire;

    assign push_ready = (used_reg != (rps_pkg::QPTR_W + 1)'(rps_pkg::QUEUE_DEPTH));
    assign pop_valid  = (used_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        used_next   = used_reg;
        if (push_fire && !pop_fire)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/rps_back.sv]
// Back end: base and count memories, count read-modify-write with forwarding, result register.
// Depends on rps_pkg and rps_if; drains rps_queue.
module rps_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  rps_pkg::queue_entry_t pop_data,
    output logic                  clearing,
    rps_out_if.source             results
);

    logic [rps_pkg::ADDR_W-1:0]  base_mem [rps_pkg::NUM_PARTS];
    logic [rps_pkg::COUNT_W-1:0] cnt_mem  [rps_pkg::NUM_PARTS];

    logic                 clearing_reg, clearing_next;
    rps_pkg::part_idx_t   clr_idx_reg, clr_idx_next;

    logic                 s2_valid_reg, s2_valid_next;
    rps_pkg::queue_entry_t s2_item_reg;
    logic [rps_pkg::COUNT_W-1:0] rd_cnt_reg;
    logic [rps_pkg::ADDR_W-1:0]  rd_base_reg;
    logic                        fwd_cnt_hit_reg, fwd_base_hit_reg;
    logic [rps_pkg::COUNT_W-1:0] fwd_cnt_val_reg;
    logic [rps_pkg::ADDR_W-1:0]  fwd_base_val_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [rps_pkg::SEL_W-1:0]   out_part_reg;
    logic [rps_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [rps_pkg::WORD_W-1:0]  out_word_reg;
    logic [rps_pkg::COUNT_W-1:0] out_fill_reg;

    logic                        s2_fire, s2_load;
    logic [rps_pkg::COUNT_W-1:0] cnt_cur, cnt_new;
    logic [rps_pkg::ADDR_W-1:0]  base_cur;
    logic                        cnt_upd, base_upd;
    logic [rps_pkg::SEL_W-1:0]   res_part;
    logic [rps_pkg::ADDR_W-1:0]  res_addr;
    logic [rps_pkg::WORD_W-1:0]  res_word;
    logic [rps_pkg::COUNT_W-1:0] res_fill;
    logic                        cnt_we;
    rps_pkg::part_idx_t          cnt_waddr;
    logic [rps_pkg::COUNT_W-1:0] cnt_wdata;

    assign clearing  = clearing_reg;
    assign s2_fire   = s2_valid_reg && (!out_valid_reg || results.ready);
    assign pop_ready = !clearing_reg && (!s2_valid_reg || s2_fire);
    assign s2_load   = pop_valid && pop_ready;

    // a write retiring now is not yet visible to the read issued in the same cycle
    assign cnt_cur  = fwd_cnt_hit_reg ? fwd_cnt_val_reg : rd_cnt_reg;
    assign base_cur = fwd_base_hit_reg ? fwd_base_val_reg : rd_base_reg;

    always_comb
    begin
        cnt_new  = cnt_cur;
        cnt_upd  = 1'b0;
        base_upd = 1'b0;
        res_part = rps_pkg::SEL_W'(s2_item_reg.idx);
        res_addr = '0;
        res_word = '0;
        res_fill = cnt_cur;
        case (s2_item_reg.op)
            rps_pkg::OP_LOAD:
            begin
                base_upd = 1'b1;
                res_addr = s2_item_reg.base_value;
            end
            rps_pkg::OP_SCATTER:
            begin
                cnt_upd  = 1'b1;
                res_addr = base_cur + cnt_cur;
                res_word = s2_item_reg.packed_word;
                cnt_new  = (cnt_cur == rps_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
            end
            rps_pkg::OP_FLUSH:
            begin
                cnt_upd  = 1'b1;
                res_addr = base_cur;
                cnt_new  = '0;
            end
            default:
            begin
                res_part = '0;
                res_fill = '0;
            end
        endcase
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_idx_reg;
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we    = s2_fire && cnt_upd;
            cnt_waddr = s2_item_reg.idx;
            cnt_wdata = cnt_new;
        end
    end

    always_comb
    begin
        clr_idx_next   = clr_idx_reg + 1'b1;
        clearing_next  = clearing_reg && (clr_idx_reg != {rps_pkg::PARTITION_BITS{1'b1}});
        s2_valid_next  = s2_load ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);
        out_valid_next = s2_fire ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_next;
            end
            clearing_reg  <= clearing_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (s2_fire && base_upd)
        begin
            base_mem[s2_item_reg.idx] <= s2_item_reg.base_value;
        end
        if (s2_load)
        begin
            rd_cnt_reg       <= cnt_mem[pop_data.idx];
            rd_base_reg      <= base_mem[pop_data.idx];
            s2_item_reg      <= pop_data;
            fwd_cnt_hit_reg  <= s2_fire && cnt_upd && (s2_item_reg.idx == pop_data.idx);
            fwd_cnt_val_reg  <= cnt_new;
            fwd_base_hit_reg <= s2_fire && base_upd && (s2_item_reg.idx == pop_data.idx);
            fwd_base_val_reg <= s2_item_reg.base_value;
        end
        if (s2_fire)
        begin
            out_part_reg <= res_part;
            out_addr_reg <= res_addr;
            out_word_reg <= res_word;
            out_fill_reg <= res_fill;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.part_id     = out_part_reg;
    assign results.write_addr  = out_addr_reg;
    assign results.packed_word = out_word_reg;
    assign results.fill_count  = out_fill_reg;

endmodule

[src/radix_partition_scatter_top.sv]
// Top level of the radix partition scatter block.
// Depends on rps_pkg, rps_if, rps_front, rps_queue and rps_back.
//
// Scatter stage of a radix hash join: each item loads a partition base, scatters a tuple
// (address = base + fill count, count then incremented and saturating), reads and clears a
// partition's count, or for any other op returns zeros. One item is accepted per cycle and
// one result leaves per cycle while results are taken and no sweep runs; the figure is set
// by the fill-count read-modify-write in the back end, which forwards the value just written
// so that tuples for the same partition can follow back to back. Items pass a four-entry
// queue, which lets the input side keep taking items while results wait, then the stage-two
// and output registers. After reset the block sweeps all 2^PARTITION_BITS count entries
// (1024 as built) to zero, one entry a cycle, and accepts no item until the sweep is done.
// Loading a partition's base before it is used is the user's job: base memory is not cleared.
module radix_partition_scatter_top
(
    input  logic      clk,
    input  logic      rst_n,
    rps_in_if.sink    tuples,
    rps_out_if.source results
);

    logic                  push_valid, push_ready;
    logic                  pop_valid, pop_ready;
    logic                  clearing;
    rps_pkg::queue_entry_t push_data, pop_data;

    rps_front u_front
    (
        .tuples     (tuples),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rps_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rps_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .clearing  (clearing),
        .results   (results)
    );

endmodule

[verif/testbench.sv]
// Self-checking bench for radix_partition_scatter_top: a table of directed items, then
// random streams; each result is checked against its table row or a behavioural model.
// Depends on rps_pkg, rps_if and the block's RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_AT     = 750;
    localparam int HOT_COUNT    = 8;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        rps_pkg::op_t                func;
        logic [rps_pkg::KEY_W-1:0]   tuple_key;
        logic [rps_pkg::RID_W-1:0]   row_id;
        logic [rps_pkg::SEL_W-1:0]   part_sel;
        logic [rps_pkg::ADDR_W-1:0]  base_value;
    } tuple_item_t;

    typedef struct packed {
        logic [rps_pkg::SEL_W-1:0]   part_id;
        logic [rps_pkg::ADDR_W-1:0]  write_addr;
        logic [rps_pkg::WORD_W-1:0]  packed_word;
        logic [rps_pkg::COUNT_W-1:0] fill_count;
    } scatter_result_t;

    typedef struct packed {
        tuple_item_t     it;
        bit              typed;
        scatter_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    rps_in_if  tuples_if();
    rps_out_if results_if();

    radix_partition_scatter_top u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tuples  (tuples_if),
        .results (results_if)
    );

    // Model state of the partitioner
    logic [rps_pkg::ADDR_W-1:0]  part_base   [rps_pkg::NUM_PARTS];
    logic [rps_pkg::COUNT_W-1:0] part_fill   [rps_pkg::NUM_PARTS];
    bit                          base_loaded [rps_pkg::NUM_PARTS];

    scatter_result_t pending_results[$];
    stim_row_t       stim_rows[$];
    int              mismatch_count;
    bit              tx_burst;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic scatter_result_t predict_partition(input tuple_item_t it);
        scatter_result_t             r;
        rps_pkg::part_idx_t          p;
        logic [rps_pkg::KEY_W-1:0]   k;
        logic [rps_pkg::COUNT_W-1:0] c;
        logic [rps_pkg::WORD_W-1:0]  hi;
        r = '0;
        p = it.part_sel[rps_pkg::PARTITION_BITS-1:0];
        case (it.func)
            rps_pkg::OP_LOAD:
            begin
                part_base[p]   = it.base_value;
                base_loaded[p] = 1'b1;
                r.part_id      = rps_pkg::SEL_W'(p);
                r.write_addr   = it.base_value;
                r.fill_count   = part_fill[p];
            end
            rps_pkg::OP_SCATTER:
            begin
                k  = it.tuple_key & rps_pkg::KEY_MASK;
                p  = k[rps_pkg::PARTITION_BITS-1:0];
                c  = part_fill[p];
                hi = rps_pkg::WORD_W'(k) >> rps_pkg::PARTITION_BITS;
                r.part_id     = rps_pkg::SEL_W'(p);
                r.write_addr  = part_base[p] + c;
                r.packed_word = rps_pkg::WORD_W'(it.row_id) + (hi << rps_pkg::PACK_SHIFT);
                r.fill_count  = c;
                // hold the count at its ceiling
                if (c != rps_pkg::COUNT_MAX)
                    part_fill[p] = c + 1'b1;
            end
            rps_pkg::OP_FLUSH:
            begin
                r.part_id    = rps_pkg::SEL_W'(p);
                r.write_addr = part_base[p];
                r.fill_count = part_fill[p];
                part_fill[p] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input rps_pkg::op_t f,
                                    input logic [rps_pkg::KEY_W-1:0] key,
                                    input logic [rps_pkg::RID_W-1:0] rid,
                                    input logic [rps_pkg::SEL_W-1:0] sel,
                                    input logic [rps_pkg::ADDR_W-1:0] base, input bit typed,
                                    input logic [rps_pkg::SEL_W-1:0] pid,
                                    input logic [rps_pkg::ADDR_W-1:0] addr,
                                    input logic [rps_pkg::WORD_W-1:0] word,
                                    input logic [rps_pkg::COUNT_W-1:0] cnt);
        stim_row_t row;
        row.it    = '{func: f, tuple_key: key, row_id: rid, part_sel: sel, base_value: base};
        row.typed = typed;
        row.res   = '{part_id: pid, write_addr: addr, packed_word: word, fill_count: cnt};
        stim_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Offer one item, hold it until the transfer, then record what it must produce.
    task automatic send_item(input tuple_item_t it, input bit drain, input bit typed,
                             input scatter_result_t typed_res);
        int              gap;
        scatter_result_t predicted;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (drain && gap == 0)
            gap = 1;
        if (gap != 0)
        begin
            tuples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain && pending_results.size() != 0)
                @(posedge clk);
        end
        tuples_if.valid      <= 1'b1;
        tuples_if.func       <= it.func;
        tuples_if.tuple_key  <= it.tuple_key;
        tuples_if.row_id     <= it.row_id;
        tuples_if.part_sel   <= it.part_sel;
        tuples_if.base_value <= it.base_value;
        do
            @(posedge clk);
        while (tuples_if.ready !== 1'b1);
        predicted = predict_partition(it);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    initial
    begin : result_sink
        int              gap;
        int              seen;
        bit              rx_burst;
        scatter_result_t exp_r;
        seen     = 0;
        rx_burst = 1'b0;
        results_if.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (seen % 100 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            gap = rx_burst ? 0 : $urandom_range(0, 3);
            // long hold-off so that the queue fills and the input stalls
            if (seen == 400 || seen == 1100)
                gap = 120;
            if (gap != 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (results_if.valid !== 1'b1);
            seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual part_id %0h addr %0h",
                         $time, results_if.part_id, results_if.write_addr);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("part_id", 64'(exp_r.part_id), 64'(results_if.part_id));
                check_field("write_addr", 64'(exp_r.write_addr), 64'(results_if.write_addr));
                check_field("packed_word", exp_r.packed_word, results_if.packed_word);
                check_field("fill_count", 64'(exp_r.fill_count), 64'(results_if.fill_count));
            end
        end
    end

    initial
    begin : tuple_source
        tuple_item_t        it;
        rps_pkg::part_idx_t hot_parts[HOT_COUNT];
        rps_pkg::part_idx_t p;
        int                 pick;

        mismatch_count = 0;
        tx_burst       = 1'b0;
        for (int i = 0; i < rps_pkg::NUM_PARTS; i++)
        begin
            part_base[i]   = '0;
            part_fill[i]   = '0;
            base_loaded[i] = 1'b0;
        end

        rst_n                <= 1'b0;
        tuples_if.valid      <= 1'b0;
        tuples_if.func       <= rps_pkg::OP_LOAD;
        tuples_if.tuple_key  <= '0;
        tuples_if.row_id     <= '0;
        tuples_if.part_sel   <= '0;
        tuples_if.base_value <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // func  key           rid           sel     base          typed pid addr word cnt
        add_row(rps_pkg::OP_NONE, '0, '0, '0, '0, 1, '0, '0, '0, '0);
        add_row(rps_pkg::OP_NONE, '1, '1, '1, '1, 1, '0, '0, '0, '0);
        add_row(rps_pkg::OP_LOAD, '0, '0, 10'd0, 32'h0, 1, 10'd0, 32'h0, '0, '0);
        add_row(rps_pkg::OP_LOAD, '1, '1, 10'h3FF, 32'hFFFF_FFFF, 1, 10'h3FF, 32'hFFFF_FFFF,
                '0, '0);
        add_row(rps_pkg::OP_LOAD, '0, '0, 10'd1, 32'h1000, 1, 10'd1, 32'h1000, '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'h0, 27'h0, '0, '0, 1, 10'd0, 32'h0, 64'h0, 32'd0);
        add_row(rps_pkg::OP_SCATTER, 32'h0, 27'h7FF_FFFF, '0, '0, 1, 10'd0, 32'h1,
                64'h7FF_FFFF, 32'd1);
        add_row(rps_pkg::OP_SCATTER, 32'h3FF, 27'h0, '0, '0, 1, 10'h3FF, 32'hFFFF_FFFF,
                64'h0, 32'd0);
        // address wraps past the top of the buffer
        add_row(rps_pkg::OP_SCATTER, 32'hFFFF_FFFF, 27'h7FF_FFFF, '1, '1, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'h401, 27'h5, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'h801, 27'h6, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'hC01, 27'h7, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_LOAD, '0, '0, 10'd1, 32'h2000, 1, 10'd1, 32'h2000, '0, 32'd3);
        add_row(rps_pkg::OP_FLUSH, '0, '0, 10'h3FF, '0, 1, 10'h3FF, 32'hFFFF_FFFF, '0, 32'd2);
        add_row(rps_pkg::OP_FLUSH, '0, '0, 10'h3FF, '0, 1, 10'h3FF, 32'hFFFF_FFFF, '0, 32'd0);
        add_row(rps_pkg::OP_SCATTER, 32'h3FF, 27'h123_4567, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_FLUSH, '0, '0, 10'd0, '0, 1, 10'd0, 32'h0, '0, 32'd2);
        add_row(rps_pkg::OP_SCATTER, 32'h8000_0000, 27'h400_0000, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_LOAD, '0, '0, 10'h2AA, 32'hAAAA_AAAA, 1, 10'h2AA, 32'hAAAA_AAAA,
                '0, '0);
        add_row(rps_pkg::OP_LOAD, '0, '0, 10'h155, 32'h5555_5555, 1, 10'h155, 32'h5555_5555,
                '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'hAAAA_AAAA, 27'h555_5555, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_SCATTER, 32'h5555_5555, 27'h2AA_AAAA, '0, '0, 0, '0, '0, '0, '0);
        add_row(rps_pkg::OP_NONE, 32'h3FF, 27'h1, 10'h155, 32'h1, 1, '0, '0, '0, '0);
        add_row(rps_pkg::OP_FLUSH, '0, '0, 10'h155, '0, 1, 10'h155, 32'h5555_5555, '0, 32'd1);
        add_row(rps_pkg::OP_FLUSH, '0, '0, 10'd1, '0, 1, 10'd1, 32'h2000, '0, 32'd3);

        foreach (stim_rows[i])
            send_item(stim_rows[i].it, 1'b0, stim_rows[i].typed, stim_rows[i].res);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 256 == 0)
                foreach (hot_parts[h])
                    hot_parts[h] = rps_pkg::part_idx_t'($urandom);
            if (n % 64 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            p = ($urandom_range(0, 3) != 0) ? hot_parts[$urandom_range(0, HOT_COUNT - 1)]
                                            : rps_pkg::part_idx_t'($urandom);
            it.tuple_key  = $urandom;
            it.row_id     = rps_pkg::RID_W'($urandom);
            it.part_sel   = rps_pkg::SEL_W'($urandom);
            it.base_value = $urandom;
            if (pick < 8)
            begin
                it.func = rps_pkg::OP_LOAD;
                if ($urandom_range(0, 1) == 0)
                    it.part_sel = rps_pkg::SEL_W'(p);
                // keep some bases near the top so that addresses wrap
                if ($urandom_range(0, 3) == 0)
                    it.base_value = 32'hFFFF_FFF0 | rps_pkg::ADDR_W'($urandom_range(0, 15));
            end
            else if (pick < 85)
            begin
                it.func = rps_pkg::OP_SCATTER;
                it.tuple_key[rps_pkg::PARTITION_BITS-1:0] = p;
            end
            else if (pick < 95)
            begin
                it.func     = rps_pkg::OP_FLUSH;
                it.part_sel = rps_pkg::SEL_W'(p);
            end
            else
                it.func = rps_pkg::OP_NONE;
            // never read a base that was not loaded: load it instead
            if ((it.func == rps_pkg::OP_SCATTER || it.func == rps_pkg::OP_FLUSH)
                && !base_loaded[p])
            begin
                it.func     = rps_pkg::OP_LOAD;
                it.part_sel = rps_pkg::SEL_W'(p);
            end
            send_item(it, n == DRAIN_AT, 1'b0, '0);
        end
        tuples_if.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
